// ===== hw/rtl/ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctr_pkg
// Types, widths and codes shared by the color transfer ramp modules.
// ----------------------------------------------------------------------------
package ctr_pkg;

  localparam int MAX_NODES   = 16;
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int N1_W        = $clog2(MAX_ENTRIES);
  localparam int ENT_W       = 9;
  localparam int POS_W       = 16;
  localparam int COL_W       = 16;
  localparam int X_W         = 26;
  localparam int MUL_W       = 18;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DIV_W       = 26;
  localparam int Q_W         = 17;
  localparam int SH_W        = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_MIN_POS = 2'd0,
    CFG_MAX_POS = 2'd1,
    CFG_ENTRIES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    NODE_NOP,
    NODE_WRITE,
    NODE_INSERT,
    NODE_REMOVE,
    NODE_CLEAR
  } node_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_EDIT,
    ST_XA,
    ST_XB,
    ST_SCAN,
    ST_DIV1,
    ST_DIV2,
    ST_BLEND
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [COL_W-1:0]        red;
    logic [COL_W-1:0]        green;
    logic [COL_W-1:0]        blue;
    logic [COL_W-1:0]        mid;
  } node_t;

  typedef struct packed {
    node_op_e         op;
    logic [IDX_W-1:0] idx;
    node_t            data;
  } node_cmd_t;

endpackage

// ===== hw/rtl/ctr_nodes.sv =====
// ----------------------------------------------------------------------------
// ctr_nodes
// Sorted node store: write, insert with shift up, remove with shift down,
// clear, and one read port.
// ----------------------------------------------------------------------------
module ctr_nodes import ctr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  node_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output node_t            rd_node_o,
  output logic [CNT_W-1:0] count_o
);

  node_t            node_q [MAX_NODES];
  logic [CNT_W-1:0] count_q;

  for (genvar j = 0; j < MAX_NODES; j++) begin : g_node
    localparam int PREV = (j == 0) ? 0 : j - 1;
    localparam int NEXT = (j == MAX_NODES - 1) ? j : j + 1;
    localparam logic [IDX_W-1:0] JIDX = IDX_W'(j);
    always_ff @(posedge clk_i) begin
      case (cmd_i.op)
        NODE_WRITE: begin
          if (cmd_i.idx == JIDX) node_q[j] <= cmd_i.data;
        end
        NODE_INSERT: begin
          if (cmd_i.idx == JIDX) node_q[j] <= cmd_i.data;
          else if (JIDX > cmd_i.idx) node_q[j] <= node_q[PREV];
        end
        NODE_REMOVE: begin
          if (JIDX >= cmd_i.idx) node_q[j] <= node_q[NEXT];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      case (cmd_i.op)
        NODE_INSERT: count_q <= count_q + CNT_W'(1);
        NODE_REMOVE: count_q <= count_q - CNT_W'(1);
        NODE_CLEAR:  count_q <= '0;
        default: ;
      endcase
    end
  end

  assign rd_node_o = node_q[rd_idx_i];
  assign count_o   = count_q;

endmodule

// ===== hw/rtl/ctr_div.sv =====
// ----------------------------------------------------------------------------
// ctr_div
// Restoring divider for fractions num/den with num <= den: one quotient
// bit per cycle after a leading compare.
// ----------------------------------------------------------------------------
module ctr_div import ctr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  input  logic [SH_W-1:0]  nshift_i,
  output logic             done_o,
  output logic [Q_W-1:0]   q_o
);

  logic             busy_q;
  logic [SH_W-1:0]  cnt_q;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] den_q;
  logic [Q_W-1:0]   q_q;
  logic [DIV_W:0]   rem2;
  logic             ge;

  assign rem2   = {rem_q[DIV_W-1:0], 1'b0};
  assign ge     = rem2 >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign q_o    = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= nshift_i;
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - SH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (num_i >= den_i) begin
        rem_q <= {1'b0, num_i - den_i};
        q_q   <= Q_W'(1);
      end else begin
        rem_q <= {1'b0, num_i};
        q_q   <= '0;
      end
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? rem2 - {1'b0, den_q} : rem2;
      q_q   <= {q_q[Q_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/color_transfer_ramp_core.sv =====
// ----------------------------------------------------------------------------
// color_transfer_ramp_core
// Piecewise linear color ramp over a sorted table of control nodes.
// Add/remove: node scan (one node per cycle), then an edit. Clear: on accept.
// Lookup: scan and mapping on the shared multiplier, two passes through the
// shared divider and a blend step for each color.
// One request at a time; the result register frees the next request.
// Reset: node count and handshake state clear; node payload stays undefined.
// ----------------------------------------------------------------------------
module color_transfer_ramp_core import ctr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position, entry_index, red_in, green_in, blue_in, midpoint_in
  input  logic [87:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out, green_out, blue_out, slot, status, zero pad
  output logic [55:0] m_axis_tdata
);

  state_e state_q, state_d;

  logic signed [POS_W-1:0] min_q, max_q;
  logic [ENT_W-1:0]        te_q;

  action_e                 act_q, act_d;
  node_t                   req_q, req_d;
  logic [7:0]              eidx_q, eidx_d;
  logic [CNT_W-1:0]        k_q, k_d, lt_q, lt_d;
  logic                    found_q, found_d;
  logic [IDX_W-1:0]        fidx_q, fidx_d;
  logic signed [X_W-1:0]   x_q, x_d, d1_q, d1_d;
  node_t                   prev_q, prev_d, cur_q, cur_d;
  logic [COL_W-1:0]        m_q, m_d;
  logic                    lo_q, lo_d;
  logic [Q_W-1:0]          w_q, w_d;
  logic [1:0]              c_q, c_d;
  logic [COL_W-1:0]        res_q [2], res_d [2];

  logic                    ovalid_q;
  logic [COL_W-1:0]        ored_q, ogrn_q, oblu_q, ored_d, ogrn_d, oblu_d;
  logic [4:0]              oslot_q, oslot_d;
  status_e                 osts_q, osts_d;
  logic                    out_load;

  node_cmd_t               cmd;
  node_t                   rd_node;
  logic [CNT_W-1:0]        count;

  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_num, div_den;
  logic [SH_W-1:0]         div_nsh;
  logic [Q_W-1:0]          div_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [N1_W-1:0]          n1, ient;
  logic signed [X_W-1:0]    t;
  logic [COL_W-1:0]         mc, c_prev, c_cur;
  logic signed [PROD_W-1:0] bsum;
  logic                     in_acc;

  ctr_nodes u_nodes (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_idx_i(k_q[IDX_W-1:0]),
    .rd_node_o(rd_node), .count_o(count)
  );

  ctr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .nshift_i(div_nsh), .done_o(div_done), .q_o(div_q)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, osts_q, oslot_q, oblu_q, ogrn_q, ored_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= 16'sd4500;
      te_q  <= ENT_W'(MAX_ENTRIES);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_POS: min_q <= cfg_data_i;
        CFG_MAX_POS: max_q <= cfg_data_i;
        CFG_ENTRIES: te_q  <= cfg_data_i[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (te_q < ENT_W'(2)) n1 = N1_W'(1);
    else if (te_q > ENT_W'(MAX_ENTRIES)) n1 = N1_W'(MAX_ENTRIES - 1);
    else n1 = N1_W'(te_q - ENT_W'(1));
    ient = (N1_W'(eidx_q) > n1) ? n1 : N1_W'(eidx_q);
    mc = (m_q < COL_W'(1)) ? COL_W'(1) : ((m_q > COL_W'(65534)) ? COL_W'(65534) : m_q);
    case (c_q)
      2'd0:    begin c_prev = prev_q.red;   c_cur = cur_q.red;   end
      2'd1:    begin c_prev = prev_q.green; c_cur = cur_q.green; end
      default: begin c_prev = prev_q.blue;  c_cur = cur_q.blue;  end
    endcase
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_XA: begin
        mul_a = MUL_W'(min_q);
        mul_b = $signed({{(MUL_W-N1_W){1'b0}}, n1});
      end
      ST_XB: begin
        mul_a = $signed({{(MUL_W-N1_W){1'b0}}, ient});
        mul_b = MUL_W'($signed({max_q[POS_W-1], max_q}) - $signed({min_q[POS_W-1], min_q}));
      end
      ST_SCAN: begin
        mul_a = MUL_W'(rd_node.pos);
        mul_b = $signed({{(MUL_W-N1_W){1'b0}}, n1});
      end
      ST_BLEND: begin
        mul_a = MUL_W'($signed({1'b0, c_cur}) - $signed({1'b0, c_prev}));
        mul_b = $signed({1'b0, w_q});
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
    t    = prod[X_W-1:0];
    bsum = $signed({{(PROD_W-COL_W-16){1'b0}}, c_prev, 16'h0000}) + prod
         + PROD_W'(32768);
  end

  always_comb begin
    state_d = state_q;
    act_d = act_q; req_d = req_q; eidx_d = eidx_q;
    k_d = k_q; lt_d = lt_q; found_d = found_q; fidx_d = fidx_q;
    x_d = x_q; d1_d = d1_q; prev_d = prev_q; cur_d = cur_q;
    m_d = m_q; lo_d = lo_q; w_d = w_q; c_d = c_q;
    res_d = res_q;
    out_load = 1'b0;
    ored_d = '0; ogrn_d = '0; oblu_d = '0; oslot_d = '0; osts_d = STS_OK;
    cmd = '{op: NODE_NOP, idx: '0, data: req_q};
    div_start = 1'b0;
    div_num = '0; div_den = '0; div_nsh = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_d  = action_e'(s_axis_tuser);
          req_d  = '{pos: s_axis_tdata[15:0], red: s_axis_tdata[39:24],
                     green: s_axis_tdata[55:40], blue: s_axis_tdata[71:56],
                     mid: s_axis_tdata[87:72]};
          eidx_d = s_axis_tdata[23:16];
          k_d = '0; lt_d = '0; found_d = 1'b0; fidx_d = '0;
          case (action_e'(s_axis_tuser))
            ACT_ADD, ACT_REMOVE: state_d = ST_FIND;
            ACT_CLEAR: begin
              cmd.op   = NODE_CLEAR;
              out_load = 1'b1;
            end
            default: begin
              if (count == '0) out_load = 1'b1;
              else state_d = ST_XA;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (k_q == count) begin
          state_d = ST_EDIT;
        end else begin
          if (rd_node.pos == req_q.pos && !found_q) begin
            found_d = 1'b1;
            fidx_d  = k_q[IDX_W-1:0];
          end
          if (rd_node.pos < req_q.pos) lt_d = lt_q + CNT_W'(1);
          k_d = k_q + CNT_W'(1);
        end
      end
      ST_EDIT: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
        if (act_q == ACT_ADD) begin
          if (found_q) begin
            cmd.op = NODE_WRITE; cmd.idx = fidx_q; oslot_d = 5'(fidx_q);
          end else if (count == CNT_W'(MAX_NODES)) begin
            osts_d = STS_FULL;
          end else begin
            cmd.op = NODE_INSERT; cmd.idx = lt_q[IDX_W-1:0]; oslot_d = 5'(lt_q);
          end
        end else begin
          if (found_q) begin
            cmd.op = NODE_REMOVE; cmd.idx = fidx_q; oslot_d = 5'(fidx_q);
          end else begin
            osts_d = STS_NOT_FOUND;
          end
        end
      end
      ST_XA: begin
        x_d = prod[X_W-1:0];
        state_d = ST_XB;
      end
      ST_XB: begin
        x_d = x_q + prod[X_W-1:0];
        k_d = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_q == count) begin
          out_load = 1'b1;
          ored_d = prev_q.red; ogrn_d = prev_q.green; oblu_d = prev_q.blue;
          state_d = ST_IDLE;
        end else if (x_q > t) begin
          prev_d = rd_node;
          d1_d   = t;
          k_d    = k_q + CNT_W'(1);
        end else if (k_q == '0) begin
          out_load = 1'b1;
          ored_d = rd_node.red; ogrn_d = rd_node.green; oblu_d = rd_node.blue;
          state_d = ST_IDLE;
        end else begin
          cur_d     = rd_node;
          m_d       = prev_q.mid;
          div_start = 1'b1;
          div_num   = DIV_W'(x_q - d1_q);
          div_den   = DIV_W'(t - d1_q);
          div_nsh   = SH_W'(16);
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_nsh   = SH_W'(15);
          if (div_q < Q_W'(mc)) begin
            lo_d = 1'b1;
            div_num = DIV_W'(div_q);
            div_den = DIV_W'(mc);
          end else begin
            lo_d = 1'b0;
            div_num = DIV_W'(div_q - Q_W'(mc));
            div_den = DIV_W'(Q_W'(65536) - Q_W'(mc));
          end
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          w_d = lo_q ? div_q : div_q + Q_W'(32768);
          c_d = '0;
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (c_q == 2'd2) begin
          out_load = 1'b1;
          ored_d = res_q[0]; ogrn_d = res_q[1]; oblu_d = bsum[31:16];
          state_d = ST_IDLE;
        end else begin
          res_d[c_q[0]] = bsum[31:16];
          c_d = c_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; req_q <= req_d; eidx_q <= eidx_d;
    k_q <= k_d; lt_q <= lt_d; found_q <= found_d; fidx_q <= fidx_d;
    x_q <= x_d; d1_q <= d1_d; prev_q <= prev_d; cur_q <= cur_d;
    m_q <= m_d; lo_q <= lo_d; w_q <= w_d; c_q <= c_d;
    res_q <= res_d;
    if (out_load) begin
      ored_q <= ored_d; ogrn_q <= ogrn_d; oblu_q <= oblu_d;
      oslot_q <= oslot_d; osts_q <= osts_d;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(MAX_NODES)) else $error("node count overflow");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready) else $error("ready while request in flight");
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && osts_q == STS_FULL) |-> (oslot_q == '0 && ored_q == '0))
    else $error("full result carries data");
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND) |-> (w_q <= Q_W'(65536))) else $error("weight range");
`endif

endmodule
